>>> rtl/mu8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mu8_pkg
// Types and constants shared by the Modified UTF-8 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package mu8_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } mu8_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } mu8_out_t;

    // One input byte's worth of output: up to four bytes, data[0] goes first.
    // A count of zero with eos set is a bare end marker.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            eos;
    } mu8_group_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TWO     = 2'd1,
        PH_THREE   = 2'd2,
        PH_THREE_B = 2'd3
    } mu8_phase_t;

    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] LEAD2_LO    = 8'hC0;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] NUL_LEAD    = 8'hC0;
    localparam logic [7:0] NUL_CONT    = 8'h80;
    localparam logic [7:0] LEAD4_MARK  = 8'hF0;
    localparam logic [7:0] CONT_MARK   = 8'h80;
    localparam logic [5:0] SURR_LEAD   = 6'b110110;
    localparam logic [5:0] SURR_TRAIL  = 6'b110111;

endpackage
`default_nettype wire

>>> rtl/mu8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mu8_front
// Accepts input bytes, tracks the sequence phase and the held surrogate,
// and turns each byte into a group of output bytes for the queue.
// ----------------------------------------------------------------------------
module mu8_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mu8_pkg::mu8_in_t   in_data,
    input  wire logic               in_accept,
    output mu8_pkg::mu8_group_t     grp,
    output logic                    grp_push
);
    import mu8_pkg::*;

    mu8_phase_t  phase_reg, phase_next;
    logic [7:0]  held_first_reg, held_first_next;
    logic [7:0]  held_second_reg, held_second_next;
    logic [9:0]  lead_bits_reg, lead_bits_next;
    logic        lead_present_reg, lead_present_next;

    logic [7:0]  b;
    logic        eos;
    logic        is_cont;
    logic [15:0] val;
    logic [4:0]  cp_hi;

    assign b       = in_data.in_byte;
    assign eos     = in_data.end_of_string;
    assign is_cont = (b inside {[CONT_LO:CONT_HI]});
    assign val     = {held_first_reg[3:0], held_second_reg[5:0], b[5:0]};
    assign cp_hi   = {1'b0, lead_bits_reg[9:6]} + 5'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            held_first_reg   <= '0;
            held_second_reg  <= '0;
            lead_bits_reg    <= '0;
            lead_present_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            held_first_reg   <= held_first_next;
            held_second_reg  <= held_second_next;
            lead_bits_reg    <= lead_bits_next;
            lead_present_reg <= lead_present_next;
        end
    end

    always_comb begin
        phase_next = PH_IDLE;
        case (phase_reg)
            PH_IDLE: begin
                if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
                    phase_next = PH_TWO;
                end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
                    phase_next = PH_THREE;
                end
            end
            PH_THREE: begin
                if (is_cont) begin
                    phase_next = PH_THREE_B;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
        if (eos) begin
            phase_next = PH_IDLE;
        end
    end

    always_comb begin
        grp               = '0;
        held_first_next   = held_first_reg;
        held_second_next  = held_second_reg;
        lead_bits_next    = lead_bits_reg;
        lead_present_next = lead_present_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (!b[7]) begin
                    grp.data[0] = b;
                    grp.count   = 3'd1;
                end else if (b inside {[LEAD2_LO:LEAD3_HI]}) begin
                    held_first_next = b;
                end
            end
            PH_TWO: begin
                if (held_first_reg == NUL_LEAD && b == NUL_CONT) begin
                    grp.data[0] = 8'h00;
                    grp.count   = 3'd1;
                end else begin
                    grp.data[0] = held_first_reg;
                    grp.data[1] = b;
                    grp.count   = 3'd2;
                end
            end
            PH_THREE: begin
                if (is_cont) begin
                    held_second_next = b;
                end
            end
            PH_THREE_B: begin
                if (is_cont) begin
                    if (val[15:10] == SURR_LEAD) begin
                        lead_bits_next    = val[9:0];
                        lead_present_next = 1'b1;
                    end else if (val[15:10] == SURR_TRAIL) begin
                        if (lead_present_reg) begin
                            grp.data[0] = LEAD4_MARK | {5'd0, cp_hi[4:2]};
                            grp.data[1] = CONT_MARK | {2'd0, cp_hi[1:0],
                                                       lead_bits_reg[5:2]};
                            grp.data[2] = CONT_MARK | {2'd0, lead_bits_reg[1:0],
                                                       val[9:6]};
                            grp.data[3] = CONT_MARK | {2'd0, val[5:0]};
                            grp.count   = 3'd4;
                        end
                        lead_bits_next    = '0;
                        lead_present_next = 1'b0;
                    end else begin
                        grp.data[0] = held_first_reg;
                        grp.data[1] = held_second_reg;
                        grp.data[2] = b;
                        grp.count   = 3'd3;
                    end
                end
            end
            default: grp = '0;
        endcase
        if (eos) begin
            grp.eos           = 1'b1;
            held_first_next   = '0;
            held_second_next  = '0;
            lead_bits_next    = '0;
            lead_present_next = 1'b0;
        end
    end

    assign grp_push = in_accept && (grp.count != 3'd0 || grp.eos);

endmodule
`default_nettype wire

>>> rtl/mu8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mu8_queue
// Short register queue of output groups between the front and back parts.
// ----------------------------------------------------------------------------
module mu8_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mu8_pkg::mu8_group_t wr_data,
    input  wire logic                push,
    input  wire logic                pop,
    output mu8_pkg::mu8_group_t      rd_data,
    output logic                     empty,
    output logic                     full
);
    import mu8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    mu8_group_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == FULL_CNT);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mu8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mu8_back
// Takes groups from the queue and sends their bytes one per transaction
// through a registered output stage.
// ----------------------------------------------------------------------------
module mu8_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mu8_pkg::mu8_group_t head,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mu8_pkg::mu8_out_t        m_data
);
    import mu8_pkg::*;

    logic       m_valid_reg, m_valid_next;
    mu8_out_t   m_data_reg, m_data_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       is_last;

    assign load    = !m_valid_reg || m_ready;
    assign is_last = (head.count == 3'd0) || ({1'b0, idx_reg} == head.count - 3'd1);
    assign pop     = load && head_valid && is_last;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next = head_valid;
            if (head_valid) begin
                m_data_next.out_byte   = (head.count == 3'd0) ? 8'h00 : head.data[idx_reg];
                m_data_next.byte_valid = (head.count != 3'd0);
                m_data_next.run_last   = is_last;
                m_data_next.string_end = is_last && head.eos;
                idx_next               = is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> rtl/modified_utf8_to_utf8_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modified_utf8_to_utf8_transcoder
// Converts a Modified UTF-8 byte stream into standard UTF-8.
//
//   Channel | Ports                    | Payload
//   input   | s_valid, s_ready, s_data | mu8_in_t  (in_byte, end_of_string)
//   output  | m_valid, m_ready, m_data | mu8_out_t (out_byte, byte_valid,
//           |                          |            run_last, string_end)
//
// One input byte is accepted per cycle while the group queue has room.
// Each byte yields zero to four output bytes, sent one per cycle from the
// output register while m_ready is high; the queue depth sets how far input
// runs ahead of output. Reset is synchronous and active low.
// A stall on the output side fills the queue, and only then lowers s_ready.
// ----------------------------------------------------------------------------
module modified_utf8_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mu8_pkg::mu8_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mu8_pkg::mu8_out_t       m_data
);
    import mu8_pkg::*;

    mu8_group_t grp;
    mu8_group_t head;
    logic       grp_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    logic       in_accept;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    mu8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .in_accept (in_accept),
        .grp       (grp),
        .grp_push  (grp_push)
    );

    mu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_data (grp),
        .push    (grp_push),
        .pop     (q_pop),
        .rd_data (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    mu8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire
